[hw/rtl/sha1s_pkg.sv]
// Shared types and constants for the SHA-1 stream hasher.
// Used by sha1s_core and sha1_stream_hasher_unit; depends on nothing else.
package sha1s_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [4:0] chain_t;

  localparam word_t H0_INIT = 32'h67452301;
  localparam word_t H1_INIT = 32'hEFCDAB89;
  localparam word_t H2_INIT = 32'h98BADCFE;
  localparam word_t H3_INIT = 32'h10325476;
  localparam word_t H4_INIT = 32'hC3D2E1F0;

  localparam word_t K_ROUND0 = 32'h5A827999;
  localparam word_t K_ROUND1 = 32'h6ED9EBA1;
  localparam word_t K_ROUND2 = 32'h8F1BBCDC;
  localparam word_t K_ROUND3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [6:0] LAST_ROUND = 7'd79;

  typedef struct packed {
    logic       push;
    logic [7:0] byte_val;
    logic       block_end;
    logic       reinit;
  } core_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

endpackage

[hw/rtl/sha1s_core.sv]
// SHA-1 block buffer, message schedule window and iterative round engine.
// Depends on sha1s_pkg for types and constants.
module sha1s_core import sha1s_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  core_ctrl_t ctrl,
  output core_stat_t stat,
  output chain_t     chain
);

  logic [511:0] blk_r;
  chain_t       h_r;
  word_t        a_r, b_r, c_r, d_r, e_r;
  logic [6:0]   round_r;
  logic         run_r;
  logic         fin_r;

  word_t w0, w2, w8, w13, x_w, new_w, f_val, k_val, t_val;

  assign w0    = blk_r[511:480];
  assign w2    = blk_r[447:416];
  assign w8    = blk_r[255:224];
  assign w13   = blk_r[95:64];
  assign x_w   = w13 ^ w8 ^ w2 ^ w0;
  assign new_w = {x_w[30:0], x_w[31]};

  always_comb begin
    if (round_r < 7'd20) begin
      f_val = (b_r & c_r) | (~b_r & d_r);
      k_val = K_ROUND0;
    end else if (round_r < 7'd40) begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K_ROUND1;
    end else if (round_r < 7'd60) begin
      f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_val = K_ROUND2;
    end else begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K_ROUND3;
    end
  end

  assign t_val = {a_r[26:0], a_r[31:27]} + f_val + e_r + k_val + w0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      fin_r   <= 1'b0;
      round_r <= '0;
      h_r     <= {H4_INIT, H3_INIT, H2_INIT, H1_INIT, H0_INIT};
    end else begin
      if (ctrl.push) begin
        blk_r <= {blk_r[503:0], ctrl.byte_val};
        if (ctrl.block_end) begin
          run_r   <= 1'b1;
          round_r <= '0;
          a_r     <= h_r[0];
          b_r     <= h_r[1];
          c_r     <= h_r[2];
          d_r     <= h_r[3];
          e_r     <= h_r[4];
        end
      end else if (run_r) begin
        blk_r   <= {blk_r[479:0], new_w};
        a_r     <= t_val;
        b_r     <= a_r;
        c_r     <= {b_r[1:0], b_r[31:2]};
        d_r     <= c_r;
        e_r     <= d_r;
        round_r <= round_r + 7'd1;
        if (round_r == LAST_ROUND) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end
      if (fin_r) begin
        fin_r   <= 1'b0;
        h_r[0]  <= h_r[0] + a_r;
        h_r[1]  <= h_r[1] + b_r;
        h_r[2]  <= h_r[2] + c_r;
        h_r[3]  <= h_r[3] + d_r;
        h_r[4]  <= h_r[4] + e_r;
      end else if (ctrl.reinit) begin
        h_r <= {H4_INIT, H3_INIT, H2_INIT, H1_INIT, H0_INIT};
      end
    end
  end

  assign stat.busy = run_r | fin_r;
  assign stat.done = fin_r;
  assign chain     = h_r;

endmodule

[hw/rtl/sha1_stream_hasher_unit.sv]
// SHA-1 stream hasher top level: byte intake, padding sequencer and digest output.
// Depends on sha1s_pkg and sha1s_core.
// One byte is taken per cycle while in_tready is high; the 64th byte of a block starts 80 rounds in the
// round unit and then the chaining add, and no further byte is taken until both are done.
// End of message pushes padding one byte a cycle and runs one or two compressions,
// then gives five digest words, one per cycle while out_tready is high.
// Synchronous active-low reset loads the initial chaining values and clears all counts.
module sha1_stream_hasher_unit import sha1s_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tuser,   // [0] byte_present
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic        out_tlast   // digest_last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PAD  = 2'd1;
  localparam logic [1:0] ST_COMP = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [5:0]  fill_r;
  logic [63:0] bitlen_r;
  logic        pad_first_r, len_phase_r, pad_active_r, msg_done_r;
  logic [2:0]  word_idx_r;

  core_ctrl_t  ctrl;
  core_stat_t  stat;
  chain_t      chain;

  logic        in_acc, out_acc, in_len, push, blk_last;
  logic [7:0]  pad_byte;

  assign in_acc   = in_tvalid & in_tready;
  assign out_acc  = out_tvalid & out_tready;
  assign in_len   = len_phase_r | (!pad_first_r && fill_r == LEN_POS);
  assign pad_byte = pad_first_r ? PAD_MARK : (in_len ? bitlen_r[63:56] : 8'h00);
  assign push     = (in_acc & in_tuser) | (state_r == ST_PAD);
  assign blk_last = fill_r == LAST_POS;

  assign ctrl.push      = push;
  assign ctrl.byte_val  = (state_r == ST_PAD) ? pad_byte : in_tdata;
  assign ctrl.block_end = push & blk_last;
  assign ctrl.reinit    = out_acc & out_tlast;

  sha1s_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .stat  (stat),
    .chain (chain)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser && blk_last) begin
            state_nxt = ST_COMP;
          end else if (in_tlast) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (blk_last) begin
          state_nxt = ST_COMP;
        end
      end
      ST_COMP: begin
        if (stat.done) begin
          if (msg_done_r) begin
            state_nxt = ST_OUT;
          end else if (pad_active_r) begin
            state_nxt = ST_PAD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_OUT: begin
        if (out_acc && out_tlast) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= '0;
      bitlen_r     <= '0;
      pad_first_r  <= 1'b0;
      len_phase_r  <= 1'b0;
      pad_active_r <= 1'b0;
      msg_done_r   <= 1'b0;
      word_idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (push) begin
        fill_r <= fill_r + 6'd1;
      end
      if (in_acc) begin
        if (in_tuser) begin
          bitlen_r <= bitlen_r + 64'd8;
        end
        if (in_tlast) begin
          pad_first_r  <= 1'b1;
          pad_active_r <= 1'b1;
        end
      end
      if (state_r == ST_PAD) begin
        pad_first_r <= 1'b0;
        if (in_len) begin
          bitlen_r    <= {bitlen_r[55:0], 8'h00};
          len_phase_r <= 1'b1;
          if (blk_last) begin
            msg_done_r <= 1'b1;
          end
        end
      end
      if (state_r == ST_COMP && state_nxt == ST_OUT) begin
        word_idx_r <= '0;
      end
      if (out_acc) begin
        word_idx_r <= word_idx_r + 3'd1;
        if (out_tlast) begin
          bitlen_r     <= '0;
          fill_r       <= '0;
          len_phase_r  <= 1'b0;
          pad_active_r <= 1'b0;
          msg_done_r   <= 1'b0;
          word_idx_r   <= '0;
        end
      end
    end
  end

  assign in_tready  = state_r == ST_IDLE;
  assign out_tvalid = state_r == ST_OUT;
  assign out_tlast  = word_idx_r == 3'd4;

  always_comb begin
    case (word_idx_r)
      3'd0:    out_tdata = chain[0];
      3'd1:    out_tdata = chain[1];
      3'd2:    out_tdata = chain[2];
      3'd3:    out_tdata = chain[3];
      default: out_tdata = chain[4];
    endcase
  end

  a_idle_core_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !stat.busy)
    else $error("Round unit busy while input is open.");

  a_done_in_comp: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> state_r == ST_COMP)
    else $error("Compression finished outside the compress state.");

  a_out_block_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> fill_r == 6'd0 && !stat.busy)
    else $error("Digest shown with a partly filled block.");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_tlast |=> in_tready && bitlen_r == 64'd0)
    else $error("Hasher did not reinitialise after the final digest word.");

endmodule
